@@ sv/swat_pkg.sv @@
// Shared constants and types for the sliding window ack table.
`timescale 1ns / 1ps

package swat_pkg;

    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam int SLIDE_MIN   = 8;
    localparam int INDEX_BITS  = 64;
    localparam int VALUE_BITS  = 32;

    typedef struct packed {
        logic shift;
        logic kill;
        logic write;
    } swat_cell_ctl_t;

endpackage

@@ sv/swat_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface swat_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] seq_index;
    logic [31:0] entry_value;

    modport source  (output valid, command, seq_index, entry_value, input ready);
    modport sink    (input valid, command, seq_index, entry_value, output ready);
    modport monitor (input valid, ready, command, seq_index, entry_value);
endinterface

interface swat_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic        out_of_window;

    modport source  (output valid, found, read_value, evicted, out_of_window, input ready);
    modport sink    (input valid, found, read_value, evicted, out_of_window, output ready);
    modport monitor (input valid, ready, found, read_value, evicted, out_of_window);
endinterface

@@ sv/swat_cell.sv @@
// One window slot: presence bit and data word, shifts from its upstream neighbor.
`timescale 1ns / 1ps

module swat_cell
    import swat_pkg::*;
#(
    parameter int DATA_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swat_cell_ctl_t       ctl,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 up_present,
    input  logic [DATA_BITS-1:0] up_data,
    output logic                 present,
    output logic [DATA_BITS-1:0] data
);

    logic                 present_reg;
    logic                 present_next;
    logic [DATA_BITS-1:0] data_reg;
    logic [DATA_BITS-1:0] data_next;

    always_comb
    begin
        present_next = present_reg;
        data_next    = data_reg;
        priority if (ctl.shift)
        begin
            present_next = up_present;
            data_next    = up_data;
        end
        else if (ctl.kill)
        begin
            present_next = 1'b0;
        end
        else if (ctl.write)
        begin
            present_next = 1'b1;
            data_next    = wr_data;
        end
        else
        begin
            present_next = present_reg;
            data_next    = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign present = present_reg;
    assign data    = data_reg;

endmodule

@@ sv/sliding_window_ack_table_core.sv @@
// Top level: sequencer driving a row of window slot cells.
//
// Usage: requests arrive on req (command, seq_index, entry_value) and each
// produces exactly one response on rsp (found, read_value, evicted,
// out_of_window). A transaction completes when valid and ready are both high.
// One request is in flight at a time; req.ready is high only while idle.
// Sequence: accept, offset compute, execute, then the response register is
// loaded. A remove hit that leaves entries then checks for a slide and
// steps the cell row in 8-slot slide steps; the first slide step needs 9
// or more leading empty slots, each further step 8 or more. An eviction
// takes the same slide check and steps, then recomputes the offset and
// executes again. Requests do not overlap: a new one is taken only after
// the previous result has reached the response register.
// If rsp is stalled, the finished result waits in the sequencer and the
// next request is not taken until the response register frees up.
// Reset clears all presence bits, the count and the base at once; no
// clearing pass is needed. Stored data is undefined until written.
`timescale 1ns / 1ps

module sliding_window_ack_table_core
    import swat_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int ENTRY_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    swat_req_if.sink   req,
    swat_rsp_if.source rsp
);

    localparam int OW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS);
    localparam logic [CW-1:0] COUNT_FULL = CW'(SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SLIDE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [63:0]           idx_reg, idx_next;
    logic [ENTRY_BITS-1:0] val_reg, val_next;
    logic [63:0]           base_reg, base_next;
    logic [OW-1:0]         off_reg, off_next;
    logic                  inwin_reg, inwin_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  evdone_reg, evdone_next;
    logic                  first_reg, first_next;
    logic                  res_found_reg, res_found_next;
    logic [31:0]           res_rd_reg, res_rd_next;
    logic                  res_ev_reg, res_ev_next;
    logic                  res_oow_reg, res_oow_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg;
    logic [31:0]           out_rd_reg;
    logic                  out_ev_reg;
    logic                  out_oow_reg;

    logic [SLOTS-1:0]      pres;
    logic [ENTRY_BITS-1:0] cell_data [SLOTS];
    logic [SLOTS-1:0]      sel;
    logic [SLOTS-1:0]      low_onehot;
    logic [SLOTS-1:0]      kill_vec;
    logic                  do_shift;
    logic                  do_write;
    logic [ENTRY_BITS-1:0] sel_data;
    logic [31:0]           sel_data32;
    logic [ENTRY_BITS-1:0] in_val;
    logic                  p_off;
    logic [63:0]           base_eff;
    logic [63:0]           diff;
    logic                  slide_cond;
    logic                  load_out;

    // value width adaptation
    generate
        if (ENTRY_BITS > VALUE_BITS)
        begin : g_wide
            assign in_val     = {{(ENTRY_BITS-VALUE_BITS){1'b0}}, req.entry_value};
            assign sel_data32 = sel_data[VALUE_BITS-1:0];
        end
        else if (ENTRY_BITS == VALUE_BITS)
        begin : g_same
            assign in_val     = req.entry_value;
            assign sel_data32 = sel_data;
        end
        else
        begin : g_narrow
            assign in_val     = req.entry_value[ENTRY_BITS-1:0];
            assign sel_data32 = {{(VALUE_BITS-ENTRY_BITS){1'b0}}, sel_data};
        end
    endgenerate

    // cell row; cell i takes from cell i+SLIDE_MIN on a shift
    generate
        for (genvar i = 0; i < SLOTS; i++)
        begin : g_cell
            swat_cell_ctl_t        ctl;
            logic                  up_p;
            logic [ENTRY_BITS-1:0] up_d;

            if (i + SLIDE_MIN < SLOTS)
            begin : g_up
                assign up_p = pres[i+SLIDE_MIN];
                assign up_d = cell_data[i+SLIDE_MIN];
            end
            else
            begin : g_top
                assign up_p = 1'b0;
                assign up_d = '0;
            end

            assign sel[i]    = (off_reg == OW'(i));
            assign ctl.shift = do_shift;
            assign ctl.kill  = kill_vec[i];
            assign ctl.write = do_write & sel[i];

            swat_cell #(
                .DATA_BITS (ENTRY_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .wr_data    (val_reg),
                .up_present (up_p),
                .up_data    (up_d),
                .present    (pres[i]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    assign low_onehot = pres & (~pres + 1'b1);
    assign p_off      = |(pres & sel);

    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sel_data = sel_data | (cell_data[i] & {ENTRY_BITS{sel[i]}});
        end
    end

    assign base_eff   = (cmd_reg == CMD_UPDATE && !evdone_reg && base_reg == 64'd0)
                        ? idx_reg : base_reg;
    assign diff       = idx_reg - base_eff;
    assign slide_cond = first_reg ? (pres[SLIDE_MIN:0] == '0)
                                  : (pres[SLIDE_MIN-1:0] == '0);
    assign load_out   = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        base_next      = base_reg;
        off_next       = off_reg;
        inwin_next     = inwin_reg;
        count_next     = count_reg;
        evdone_next    = evdone_reg;
        first_next     = first_reg;
        res_found_next = res_found_reg;
        res_rd_next    = res_rd_reg;
        res_ev_next    = res_ev_reg;
        res_oow_next   = res_oow_reg;
        do_shift       = 1'b0;
        do_write       = 1'b0;
        kill_vec       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.command;
                    idx_next    = req.seq_index;
                    val_next    = in_val;
                    evdone_next = 1'b0;
                    res_ev_next = 1'b0;
                    state_next  = S_CALC;
                end
            end
            S_CALC:
            begin
                base_next  = base_eff;
                inwin_next = (idx_reg >= base_eff) && (diff < 64'(SLOTS));
                off_next   = diff[OW-1:0];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_found_next = 1'b0;
                res_rd_next    = '0;
                res_oow_next   = 1'b0;
                state_next     = S_FIN;
                if (cmd_reg == CMD_UPDATE || cmd_reg == CMD_REMOVE
                    || cmd_reg == CMD_LOOKUP)
                begin
                    if (!inwin_reg)
                    begin
                        res_oow_next = 1'b1;
                    end
                    else if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_found_next = p_off;
                        res_rd_next    = p_off ? sel_data32 : '0;
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        if (p_off)
                        begin
                            res_found_next = 1'b1;
                            kill_vec       = sel;
                            count_next     = count_reg - 1'b1;
                            if (count_reg == CW'(1))
                            begin
                                base_next = '0;
                            end
                            else
                            begin
                                first_next = 1'b1;
                                state_next = S_SLIDE;
                            end
                        end
                    end
                    else if (count_reg == COUNT_FULL && !evdone_reg && pres != '0)
                    begin
                        // evict the eldest, then recompute the offset
                        kill_vec    = low_onehot;
                        res_ev_next = 1'b1;
                        evdone_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                        if (count_reg == CW'(1))
                        begin
                            base_next  = '0;
                            state_next = S_CALC;
                        end
                        else
                        begin
                            first_next = 1'b1;
                            state_next = S_SLIDE;
                        end
                    end
                    else
                    begin
                        res_found_next = p_off;
                        do_write       = 1'b1;
                        if (!p_off)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            S_SLIDE:
            begin
                if (slide_cond)
                begin
                    do_shift   = 1'b1;
                    base_next  = base_reg + 64'(SLIDE_MIN);
                    first_next = 1'b0;
                end
                else
                begin
                    state_next = evdone_reg ? S_CALC : S_FIN;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            count_reg     <= '0;
            evdone_reg    <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            evdone_reg    <= evdone_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        off_reg       <= off_next;
        inwin_reg     <= inwin_next;
        res_found_reg <= res_found_next;
        res_rd_reg    <= res_rd_next;
        res_ev_reg    <= res_ev_next;
        res_oow_reg   <= res_oow_next;
        if (load_out)
        begin
            out_found_reg <= res_found_reg;
            out_rd_reg    <= res_rd_reg;
            out_ev_reg    <= res_ev_reg;
            out_oow_reg   <= res_oow_reg;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.read_value    = out_rd_reg;
    assign rsp.evicted       = out_ev_reg;
    assign rsp.out_of_window = out_oow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count exceeds capacity");

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (pres == '0))
        else $error("presence bits set with zero count");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && out_valid_reg) |-> rsp.ready)
        else $error("response overwritten while stalled");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        do_shift |-> (count_reg != '0 && pres[SLIDE_MIN-1:0] == '0))
        else $error("slide would drop live entries");

endmodule
